[rtl/core/hsi2rgb_pkg.sv]
// hsi2rgb_pkg: widths, fixed-point constants and the ratio rom builder for the
// hsi to rgb converter core. no dependencies.
package hsi2rgb_pkg;

    localparam int HUE_BITS         = 16;
    localparam int RATIO_TABLE_BITS = 10;
    localparam int TABLE_SIZE       = 1 << RATIO_TABLE_BITS;
    localparam int IDX_RSHIFT = (HUE_BITS > RATIO_TABLE_BITS) ? HUE_BITS - RATIO_TABLE_BITS : 0;
    localparam int IDX_LSHIFT = (RATIO_TABLE_BITS > HUE_BITS) ? RATIO_TABLE_BITS - HUE_BITS : 0;

    // port field widths
    localparam int HUE_W   = 16;
    localparam int UNIT_W  = 17;
    localparam int LEVEL_W = 8;
    localparam int S_DATA_W = 56;
    localparam int M_DATA_W = 24;

    localparam logic [UNIT_W-1:0] UNIT_Q16 = 17'd65536;

    // datapath widths
    localparam int RATIO_W = 16;  // q2.14 signed
    localparam int INT255_W = 24; // 255 * intensity
    localparam int TERM_W  = 33;  // clamped q30 channel term, non-negative
    localparam int PROD_W  = INT255_W + TERM_W;
    localparam int SCALE_SHIFT = 46;
    localparam int WIDE_W  = PROD_W - SCALE_SHIFT; // level * 3 before clamp
    localparam logic [WIDE_W-1:0] CLAMP_AT = 11'd768;
    localparam logic [9:0] RECIP3 = 10'd683;     // 2^11 / 3, rounded up

    localparam logic [1:0] SECTOR_0 = 2'd0;
    localparam logic [1:0] SECTOR_1 = 2'd1;
    localparam logic [1:0] SECTOR_2 = 2'd2;

    localparam logic [63:0] Q30_ONE     = 64'd1073741824;
    localparam logic [63:0] PI3_Q30     = 64'd1124419809;
    localparam logic [63:0] TWO_PI3_Q30 = 64'd2248839617;
    localparam logic [63:0] S3H_Q30     = 64'd929887697;

    typedef logic signed [RATIO_W-1:0] ratio_t;
    typedef ratio_t ratio_rom_t [TABLE_SIZE];

    typedef struct packed {
        logic [TERM_W-1:0] x;
        logic [TERM_W-1:0] y;
        logic [TERM_W-1:0] z;
    } term_set_t;

    // restoring long division, used only while the rom is built
    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] quo;
        logic [64:0] rem;
        quo = '0;
        rem = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[63:0], num[b]};
            if (rem >= {1'b0, den}) begin
                rem    = rem - {1'b0, den};
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // cos(h)/cos(60deg-h) = 0.5 - (sqrt3/2)*tan(h - 60deg), taylor series in q30
    function automatic ratio_t ratio_entry(input int unsigned idx);
        logic [63:0] h;
        logic [63:0] a;
        logic [63:0] a2;
        logic [63:0] st;
        logic [63:0] ct;
        logic [63:0] t;
        logic [63:0] q;
        logic signed [63:0] s;
        logic signed [63:0] c;
        logic signed [63:0] r;
        logic neg;
        h   = (64'(idx) * TWO_PI3_Q30) >> RATIO_TABLE_BITS;
        neg = (h < PI3_Q30);
        a   = neg ? PI3_Q30 - h : h - PI3_Q30;
        a2  = (a * a) >> 30;
        st  = a;
        ct  = Q30_ONE;
        s   = $signed(a);
        c   = $signed(Q30_ONE);
        for (int k = 1; k <= 12; k++) begin
            st = udiv64((st * a2) >> 30, 64'((2 * k) * (2 * k + 1)));
            ct = udiv64((ct * a2) >> 30, 64'((2 * k - 1) * (2 * k)));
            if ((k & 1) != 0) begin
                s = s - $signed(st);
                c = c - $signed(ct);
            end else begin
                s = s + $signed(st);
                c = c + $signed(ct);
            end
        end
        if (s < 0) s = 0;
        if (c < 1) c = 1;
        t = udiv64(S3H_Q30 * $unsigned(s), $unsigned(c));
        q = (t + 64'd32768) >> 16;
        r = neg ? 64'sd8192 + $signed(q) : 64'sd8192 - $signed(q);
        if (r > 64'sd32767) r = 64'sd32767;
        if (r < -64'sd32768) r = -64'sd32768;
        return r[RATIO_W-1:0];
    endfunction

    function automatic ratio_rom_t build_ratio_rom();
        ratio_rom_t rom;
        for (int i = 0; i < TABLE_SIZE; i++) begin
            rom[i] = ratio_entry(i);
        end
        return rom;
    endfunction

endpackage

[rtl/core/hsi_to_rgb_converter_core.sv]
// hsi_to_rgb_converter_core: five-stage hsi to rgb pipeline, top level.
// depends on hsi2rgb_pkg, hsi2rgb_ratio_rom, hsi2rgb_terms, hsi2rgb_lane.
//
//   port group | dir | word layout, lsb first
//   s_*        | in  | hue[15:0] saturation[32:16] intensity[49:33] zero pad
//   m_*        | out | red[7:0] green[15:8] blue[23:16]
//
// one word per cycle sustained while m_tready holds high.
// stages: sector/index, rom read, terms, product, level and output register.
// the whole pipe advances while the output register is empty or taken.
// aresetn clears the valid bits only; data registers carry no reset.
module hsi_to_rgb_converter_core
    import hsi2rgb_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // hue, saturation, intensity
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata    // red, green, blue
);

    localparam int IDX_WIDE_W = HUE_BITS + RATIO_TABLE_BITS;

    logic adv;

    logic [4:0] valid_reg;
    logic [4:0] valid_next;

    // stage 1 inputs
    logic [HUE_BITS-1:0]         hue_m;
    logic [HUE_BITS+1:0]         hue3;
    logic [1:0]                  sector_c;
    logic [HUE_BITS-1:0]         pos;
    logic [IDX_WIDE_W-1:0]       idx_wide;
    logic [UNIT_W-1:0]           sat_in;
    logic [UNIT_W-1:0]           int_in;

    logic [1:0]                  sector1_reg, sector2_reg, sector3_reg, sector4_reg;
    logic [RATIO_TABLE_BITS-1:0] idx1_reg;
    logic [UNIT_W-1:0]           sat1_reg, sat2_reg;
    logic [UNIT_W-1:0]           int1_reg;
    logic [INT255_W-1:0]         int255_2_reg, int255_3_reg;

    ratio_t                      ratio;
    term_set_t                   terms;
    logic [LEVEL_W-1:0]          lvl_x, lvl_y, lvl_z;
    logic [M_DATA_W-1:0]         out_next;
    logic [M_DATA_W-1:0]         out_reg;

    assign adv      = !valid_reg[4] || m_tready;
    assign s_tready = adv;

    always_comb begin
        hue_m    = HUE_BITS'(s_tdata[HUE_W-1:0]);
        hue3     = {2'b00, hue_m} + {1'b0, hue_m, 1'b0};
        sector_c = (hue3[HUE_BITS+1:HUE_BITS] == 2'd3) ? SECTOR_2
                                                       : hue3[HUE_BITS+1:HUE_BITS];
        pos      = hue3[HUE_BITS-1:0];
        idx_wide = (IDX_WIDE_W'(pos) >> IDX_RSHIFT) << IDX_LSHIFT;
        sat_in   = s_tdata[HUE_W+UNIT_W-1:HUE_W];
        int_in   = s_tdata[HUE_W+2*UNIT_W-1:HUE_W+UNIT_W];
        if (sat_in > UNIT_Q16) sat_in = UNIT_Q16;
        if (int_in > UNIT_Q16) int_in = UNIT_Q16;
    end

    assign valid_next = {valid_reg[3:0], s_tvalid};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (adv) begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            sector1_reg  <= sector_c;
            idx1_reg     <= idx_wide[RATIO_TABLE_BITS-1:0];
            sat1_reg     <= sat_in;
            int1_reg     <= int_in;
            sector2_reg  <= sector1_reg;
            sat2_reg     <= sat1_reg;
            int255_2_reg <= (INT255_W'(int1_reg) << 8) - INT255_W'(int1_reg);
            sector3_reg  <= sector2_reg;
            int255_3_reg <= int255_2_reg;
            sector4_reg  <= sector3_reg;
            out_reg      <= out_next;
        end
    end

    hsi2rgb_ratio_rom u_rom (
        .aclk  (aclk),
        .en    (adv),
        .idx   (idx1_reg),
        .ratio (ratio)
    );

    hsi2rgb_terms u_terms (
        .aclk  (aclk),
        .en    (adv),
        .sat   (sat2_reg),
        .ratio (ratio),
        .terms (terms)
    );

    hsi2rgb_lane u_lane_x (
        .aclk   (aclk),
        .en     (adv),
        .int255 (int255_3_reg),
        .term   (terms.x),
        .level  (lvl_x)
    );

    hsi2rgb_lane u_lane_y (
        .aclk   (aclk),
        .en     (adv),
        .int255 (int255_3_reg),
        .term   (terms.y),
        .level  (lvl_y)
    );

    hsi2rgb_lane u_lane_z (
        .aclk   (aclk),
        .en     (adv),
        .int255 (int255_3_reg),
        .term   (terms.z),
        .level  (lvl_z)
    );

    // sector rotates which channel leads
    always_comb begin
        case (sector4_reg)
            SECTOR_0: out_next = {lvl_z, lvl_y, lvl_x};
            SECTOR_1: out_next = {lvl_y, lvl_x, lvl_z};
            default:  out_next = {lvl_x, lvl_z, lvl_y};
        endcase
    end

    assign m_tvalid = valid_reg[4];
    assign m_tdata  = out_reg;

endmodule

[rtl/core/hsi2rgb_ratio_rom.sv]
// hsi2rgb_ratio_rom: constant ratio rom with registered read data.
// depends on hsi2rgb_pkg.
module hsi2rgb_ratio_rom
    import hsi2rgb_pkg::*;
(
    input  logic                        aclk,
    input  logic                        en,
    input  logic [RATIO_TABLE_BITS-1:0] idx,
    output ratio_t                      ratio
);

    localparam ratio_rom_t RATIO_ROM = build_ratio_rom();

    ratio_t ratio_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            ratio_reg <= RATIO_ROM[idx];
        end
    end

    assign ratio = ratio_reg;

endmodule

[rtl/core/hsi2rgb_terms.sv]
// hsi2rgb_terms: q30 channel terms 1+S*R, 1+S*(1-R) and 1-S, clamped at zero.
// depends on hsi2rgb_pkg.
module hsi2rgb_terms
    import hsi2rgb_pkg::*;
(
    input  logic              aclk,
    input  logic              en,
    input  logic [UNIT_W-1:0] sat,
    input  ratio_t            ratio,
    output term_set_t         terms
);

    logic signed [UNIT_W:0]    sat_s;
    logic signed [RATIO_W+1:0] rest_s;
    logic signed [35:0]        sx;
    logic signed [35:0]        sy;
    logic [30:0]               sz;
    term_set_t                 terms_next;
    term_set_t                 terms_reg;

    always_comb begin
        sat_s  = $signed({1'b0, sat});
        rest_s = 18'sd16384 - 18'(ratio);
        sx = 36'sd1073741824 + 36'(sat_s * 36'(ratio));
        sy = 36'sd1073741824 + 36'(sat_s * 36'(rest_s));
        sz = 31'(UNIT_Q16 - sat) << 14;
        terms_next.x = (sx <= 0) ? '0 : sx[TERM_W-1:0];
        terms_next.y = (sy <= 0) ? '0 : sy[TERM_W-1:0];
        terms_next.z = TERM_W'(sz);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            terms_reg <= terms_next;
        end
    end

    assign terms = terms_reg;

endmodule

[rtl/core/hsi2rgb_lane.sv]
// hsi2rgb_lane: one channel, 255*I*term scaled down, divided by three, clamped.
// depends on hsi2rgb_pkg.
module hsi2rgb_lane
    import hsi2rgb_pkg::*;
(
    input  logic                aclk,
    input  logic                en,
    input  logic [INT255_W-1:0] int255,
    input  logic [TERM_W-1:0]   term,
    output logic [LEVEL_W-1:0]  level
);

    logic [PROD_W-1:0] prod;
    logic [WIDE_W-1:0] wide_reg;
    logic [19:0]       third;

    assign prod = PROD_W'(int255) * PROD_W'(term);

    always_ff @(posedge aclk) begin
        if (en) begin
            wide_reg <= prod[PROD_W-1:SCALE_SHIFT];
        end
    end

    // exact divide by three for values below 768
    assign third = 20'(wide_reg[9:0]) * 20'(RECIP3);
    assign level = (wide_reg >= CLAMP_AT) ? 8'd255 : third[18:11];

endmodule
